// File: rtl/core/rlspe_pkg.sv
// ----------------------------------------------------------------------------
// rlspe_pkg
// Types and constants shared by the RGB LED SPI pulse encoder.
// ----------------------------------------------------------------------------
package rlspe_pkg;

    localparam int CNT_W   = 5;
    localparam int COLOR_W = 24;

    localparam logic [CNT_W-1:0] BYTES_PER_LED_BYTE = 5'd24;
    localparam logic [CNT_W-1:0] BYTES_PER_LED_NIB  = 5'd12;

    localparam logic [7:0] PAD_BYTE = 8'h00;

    localparam logic [2:0] REG_PACKING_MODE    = 3'd0;
    localparam logic [2:0] REG_ONE_BYTE        = 3'd1;
    localparam logic [2:0] REG_ZERO_BYTE       = 3'd2;
    localparam logic [2:0] REG_ONE_NIBBLE      = 3'd3;
    localparam logic [2:0] REG_ZERO_NIBBLE     = 3'd4;
    localparam logic [2:0] REG_PREFIX_COUNT    = 3'd5;
    localparam logic [2:0] REG_SUFFIX_COUNT    = 3'd6;
    localparam logic [2:0] REG_EARLIER_HIGH    = 3'd7;

    typedef struct packed {
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] blue;
        logic       last_led;
    } in_word_t;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic       run_last;
        logic       frame_end;
    } out_word_t;

    typedef struct packed {
        logic             packing_mode;
        logic [7:0]       one_pattern_byte;
        logic [7:0]       zero_pattern_byte;
        logic [3:0]       one_pattern_nibble;
        logic [3:0]       zero_pattern_nibble;
        logic [CNT_W-1:0] prefix_count;
        logic [CNT_W-1:0] suffix_count;
        logic             earlier_bit_high_nibble;
    } cfg_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               last_led;
        logic [CNT_W-1:0]   pre;
        logic [CNT_W-1:0]   suf;
    } job_t;

endpackage

// File: rtl/core/rgb_led_spi_pulse_encoder_core.sv
// ----------------------------------------------------------------------------
// rgb_led_spi_pulse_encoder_core
// Turns LED colour words into SPI pattern bytes with frame padding.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload
// in        in_valid / in_ready    in_word   (green, red, blue, last_led)
// out       out_valid / out_ready  out_word  (spi_byte, run_last, frame_end)
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One SPI byte per cycle leaves the busy byte sequencer unless out_ready stalls
// it: an LED takes 24 bytes in byte packing, 12 in nibble packing, plus prefix
// and suffix bytes. A two-entry job queue lets input words land while the
// sequencer is busy; after it runs dry, the next job is loaded before its first byte.
// Reset clears frame state, queue and output; registers take their defaults.
// Output stalls back up through the sequencer into the queue and then in_ready.
// ----------------------------------------------------------------------------
module rgb_led_spi_pulse_encoder_core
    import rlspe_pkg::*;
#(
    parameter int MAX_PAD = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_word_t   in_word,
    output logic       out_valid,
    input  logic       out_ready,
    output out_word_t  out_word,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic q_full;
    logic q_push;
    job_t q_push_job;
    logic q_pop;
    logic q_not_empty;
    job_t q_head_job;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_PACKING_MODE: cfg_next.packing_mode        = cfg_data[0];
                REG_ONE_BYTE:     cfg_next.one_pattern_byte    = cfg_data;
                REG_ZERO_BYTE:    cfg_next.zero_pattern_byte   = cfg_data;
                REG_ONE_NIBBLE:   cfg_next.one_pattern_nibble  = cfg_data[3:0];
                REG_ZERO_NIBBLE:  cfg_next.zero_pattern_nibble = cfg_data[3:0];
                REG_PREFIX_COUNT: cfg_next.prefix_count        = cfg_data[CNT_W-1:0];
                REG_SUFFIX_COUNT: cfg_next.suffix_count        = cfg_data[CNT_W-1:0];
                REG_EARLIER_HIGH: cfg_next.earlier_bit_high_nibble = cfg_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.packing_mode            <= 1'b0;
            cfg_reg.one_pattern_byte        <= 8'd248;
            cfg_reg.zero_pattern_byte       <= 8'd192;
            cfg_reg.one_pattern_nibble      <= 4'd14;
            cfg_reg.zero_pattern_nibble     <= 4'd8;
            cfg_reg.prefix_count            <= 5'd1;
            cfg_reg.suffix_count            <= 5'd1;
            cfg_reg.earlier_bit_high_nibble <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rlspe_front #(
        .MAX_PAD (MAX_PAD)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_push_job)
    );

    rlspe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (q_push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_job  (q_head_job)
    );

    rlspe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_job       (q_head_job),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_word    (out_word)
    );

endmodule

// File: rtl/core/rlspe_front.sv
// ----------------------------------------------------------------------------
// rlspe_front
// Accepts LED words, tracks frame state and resolves padding lengths.
// ----------------------------------------------------------------------------
module rlspe_front
    import rlspe_pkg::*;
#(
    parameter int MAX_PAD = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_word_t in_word,
    input  logic     q_full,
    output logic     q_push,
    output job_t     q_job
);

    localparam logic [CNT_W-1:0] PAD_MAX = CNT_W'(MAX_PAD);

    logic inside_frame_reg;
    logic inside_frame_next;
    logic [CNT_W-1:0] pre_clamped;
    logic [CNT_W-1:0] suf_clamped;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    assign pre_clamped = (cfg.prefix_count > PAD_MAX) ? PAD_MAX : cfg.prefix_count;
    assign suf_clamped = (cfg.suffix_count > PAD_MAX) ? PAD_MAX : cfg.suffix_count;

    always_comb
    begin
        q_job.color    = {in_word.green, in_word.red, in_word.blue};
        q_job.last_led = in_word.last_led;
        q_job.pre      = inside_frame_reg ? '0 : pre_clamped;
        q_job.suf      = in_word.last_led ? suf_clamped : '0;
    end

    assign inside_frame_next = q_push ? !in_word.last_led : inside_frame_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_frame_reg <= 1'b0;
        end
        else
        begin
            inside_frame_reg <= inside_frame_next;
        end
    end

endmodule

// File: rtl/core/rlspe_queue.sv
// ----------------------------------------------------------------------------
// rlspe_queue
// Two-entry queue of resolved jobs between front and back.
// ----------------------------------------------------------------------------
module rlspe_queue
    import rlspe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output job_t head_job
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_job  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/core/rlspe_back.sv
// ----------------------------------------------------------------------------
// rlspe_back
// Byte sequencer: prefix, colour bit patterns, suffix, into an output register.
// ----------------------------------------------------------------------------
module rlspe_back
    import rlspe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      q_not_empty,
    input  job_t      q_job,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    localparam logic [1:0] PH_PRE = 2'd0;
    localparam logic [1:0] PH_COL = 2'd1;
    localparam logic [1:0] PH_SUF = 2'd2;

    logic               busy_reg, busy_next;
    logic [1:0]         phase_reg, phase_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [COLOR_W-1:0] sh_reg, sh_next;
    logic               last_reg, last_next;
    logic [CNT_W-1:0]   suf_reg, suf_next;
    logic               out_valid_reg, out_valid_next;
    out_word_t          out_word_reg, out_word_next;

    logic       out_free;
    logic       emit;
    logic       done;
    logic       load;
    logic [3:0] nib_first;
    logic [3:0] nib_second;
    logic [7:0] col_byte;

    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = busy_reg && out_free;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_comb
    begin
        nib_first  = sh_reg[COLOR_W-1] ? cfg.one_pattern_nibble : cfg.zero_pattern_nibble;
        nib_second = sh_reg[COLOR_W-2] ? cfg.one_pattern_nibble : cfg.zero_pattern_nibble;
        if (cfg.packing_mode)
        begin
            col_byte = cfg.earlier_bit_high_nibble ? {nib_first, nib_second}
                                                   : {nib_second, nib_first};
        end
        else
        begin
            col_byte = sh_reg[COLOR_W-1] ? cfg.one_pattern_byte : cfg.zero_pattern_byte;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        sh_next        = sh_reg;
        last_next      = last_reg;
        suf_next       = suf_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && !out_ready;
        done           = 1'b0;

        if (emit)
        begin
            out_valid_next          = 1'b1;
            out_word_next.spi_byte  = PAD_BYTE;
            out_word_next.run_last  = 1'b0;
            out_word_next.frame_end = 1'b0;
            case (phase_reg)
                PH_PRE:
                begin
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        phase_next = PH_COL;
                    end
                end
                PH_COL:
                begin
                    out_word_next.spi_byte = col_byte;
                    rem_next = rem_reg - 1'b1;
                    sh_next  = cfg.packing_mode ? {sh_reg[COLOR_W-3:0], 2'b00}
                                                : {sh_reg[COLOR_W-2:0], 1'b0};
                    if (rem_reg == CNT_W'(1))
                    begin
                        if (last_reg && (suf_reg != '0))
                        begin
                            phase_next = PH_SUF;
                            cnt_next   = suf_reg;
                        end
                        else
                        begin
                            done                    = 1'b1;
                            out_word_next.run_last  = 1'b1;
                            out_word_next.frame_end = last_reg;
                        end
                    end
                end
                PH_SUF:
                begin
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        done                    = 1'b1;
                        out_word_next.run_last  = 1'b1;
                        out_word_next.frame_end = 1'b1;
                    end
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase
        end

        load  = q_not_empty && (!busy_reg || done);
        q_pop = load;
        busy_next = load ? 1'b1 : (busy_reg && !done);

        if (load)
        begin
            phase_next = (q_job.pre != '0) ? PH_PRE : PH_COL;
            cnt_next   = q_job.pre;
            rem_next   = cfg.packing_mode ? BYTES_PER_LED_NIB : BYTES_PER_LED_BYTE;
            sh_next    = q_job.color;
            last_next  = q_job.last_led;
            suf_next   = q_job.suf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_PRE;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg       <= sh_next;
        last_reg     <= last_next;
        suf_reg      <= suf_next;
        out_word_reg <= out_word_next;
    end

endmodule

// File: tb/rgb_led_spi_pulse_encoder_core_tb.sv
// ----------------------------------------------------------------------------
// rgb_led_spi_pulse_encoder_core_tb
// Self-checking regression for the RGB LED SPI pulse encoder core. LED words
// are sent over the input channel under random gaps and output back-pressure.
// A local encoder model turns every accepted word into its expected SPI bytes:
// prefix, colour patterns and suffix, with the run_last and frame_end flags.
// Each output byte is checked field by field against the oldest expected byte.
// Byte and nibble packing, pattern and padding extremes, pad saturation,
// settings changed inside a frame and a long receiver stall are covered
// before a randomized run over several register settings.
// ----------------------------------------------------------------------------
module rgb_led_spi_pulse_encoder_core_tb
    import rlspe_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PAD = 16;
    localparam int LIMIT   = 200000;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    in_word_t   in_word   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_word_t  out_word;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_data  = '0;

    cfg_t       shadow_regs;
    logic       in_frame;
    out_word_t  spi_bytes_due[$];
    out_word_t  due_word;
    int         mismatches = 0;
    int         cycles     = 0;
    int         hold_until = 0;
    logic       gaps_on    = 1'b1;

    rgb_led_spi_pulse_encoder_core #(.MAX_PAD(MAX_PAD)) uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("rgb_led_spi_pulse_encoder_core regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (cycles < hold_until)
            out_ready <= 1'b0;
        else
            out_ready <= !(gaps_on && $urandom_range(99) < 26);
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatches < 50)
            $display("ERROR %0t: %s got %0h want %0h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (spi_bytes_due.size() == 0)
                report_mismatch("byte with none expected", out_word.spi_byte, 8'h00);
            else
            begin
                due_word = spi_bytes_due.pop_front();
                if (out_word.spi_byte !== due_word.spi_byte)
                    report_mismatch("spi_byte", out_word.spi_byte, due_word.spi_byte);
                if (out_word.run_last !== due_word.run_last)
                    report_mismatch("run_last", 8'(out_word.run_last), 8'(due_word.run_last));
                if (out_word.frame_end !== due_word.frame_end)
                    report_mismatch("frame_end", 8'(out_word.frame_end),
                                    8'(due_word.frame_end));
            end
        end
    end

    function automatic logic [3:0] nibble_of(input logic bit_val);
        return bit_val ? shadow_regs.one_pattern_nibble : shadow_regs.zero_pattern_nibble;
    endfunction

    function automatic int clamp_pad(input logic [4:0] n);
        return (n > MAX_PAD) ? MAX_PAD : int'(n);
    endfunction

    task automatic push_byte(input logic [7:0] v, inout int left, input logic closes);
        left--;
        spi_bytes_due.push_back({v, left == 0, (left == 0) && closes});
    endtask

    task automatic encode_led(input in_word_t w);
        logic [23:0] colors;
        logic [3:0]  early, late;
        int          pre, suf, left, k;
        colors = {w.green, w.red, w.blue};
        pre    = in_frame ? 0 : clamp_pad(shadow_regs.prefix_count);
        suf    = w.last_led ? clamp_pad(shadow_regs.suffix_count) : 0;
        left   = pre + (shadow_regs.packing_mode ? 12 : 24) + suf;
        for (k = 0; k < pre; k++)
            push_byte(PAD_BYTE, left, w.last_led);
        if (!shadow_regs.packing_mode)
        begin
            for (k = 23; k >= 0; k--)
                push_byte(colors[k] ? shadow_regs.one_pattern_byte
                                    : shadow_regs.zero_pattern_byte, left, w.last_led);
        end
        else
        begin
            for (k = 23; k > 0; k -= 2)
            begin
                early = nibble_of(colors[k]);
                late  = nibble_of(colors[k-1]);
                push_byte(shadow_regs.earlier_bit_high_nibble ? {early, late} : {late, early},
                          left, w.last_led);
            end
        end
        for (k = 0; k < suf; k++)
            push_byte(PAD_BYTE, left, w.last_led);
        in_frame = !w.last_led;
    endtask

    task automatic apply_reg(input logic [2:0] idx, input logic [7:0] data);
        case (idx)
            REG_PACKING_MODE: shadow_regs.packing_mode            = data[0];
            REG_ONE_BYTE:     shadow_regs.one_pattern_byte        = data;
            REG_ZERO_BYTE:    shadow_regs.zero_pattern_byte       = data;
            REG_ONE_NIBBLE:   shadow_regs.one_pattern_nibble      = data[3:0];
            REG_ZERO_NIBBLE:  shadow_regs.zero_pattern_nibble     = data[3:0];
            REG_PREFIX_COUNT: shadow_regs.prefix_count            = data[4:0];
            REG_SUFFIX_COUNT: shadow_regs.suffix_count            = data[4:0];
            REG_EARLIER_HIGH: shadow_regs.earlier_bit_high_nibble = data[0];
            default:          ;
        endcase
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, data);
    endtask

    // fill unused data bits with noise; the block must mask them
    task automatic write_all(input cfg_t c);
        write_reg(REG_PACKING_MODE, {7'($urandom), c.packing_mode});
        write_reg(REG_ONE_BYTE,     c.one_pattern_byte);
        write_reg(REG_ZERO_BYTE,    c.zero_pattern_byte);
        write_reg(REG_ONE_NIBBLE,   {4'($urandom), c.one_pattern_nibble});
        write_reg(REG_ZERO_NIBBLE,  {4'($urandom), c.zero_pattern_nibble});
        write_reg(REG_PREFIX_COUNT, {3'($urandom), c.prefix_count});
        write_reg(REG_SUFFIX_COUNT, {3'($urandom), c.suffix_count});
        write_reg(REG_EARLIER_HIGH, {7'($urandom), c.earlier_bit_high_nibble});
        cfg_valid <= 1'b0;
    endtask

    function automatic cfg_t reg_set(input logic pm, input logic [7:0] ob, zb,
                                     input logic [3:0] on, zn, input logic [4:0] pre, suf,
                                     input logic eh);
        return {pm, ob, zb, on, zn, pre, suf, eh};
    endfunction

    task automatic send_led(input logic [7:0] g, r, b, input logic last);
        if (gaps_on && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 26);
        end
        in_valid <= 1'b1;
        in_word  <= {g, r, b, last};
        do @(posedge clk); while (!in_ready);
        encode_led({g, r, b, last});
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (spi_bytes_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_reset_defaults;
        send_led(8'h00, 8'h00, 8'h00, 1'b0);
        send_led(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_led(8'h80, 8'h01, 8'hA5, 1'b1);
        send_led(8'h5A, 8'hC3, 8'h3C, 1'b1);
        drain();
    endtask

    task automatic test_byte_packing;
        write_all(reg_set(1'b0, 8'hFF, 8'h00, 4'hE, 4'h8, 5'd0, 5'd0, 1'b1));
        send_led(8'h12, 8'h34, 8'h56, 1'b0);
        send_led(8'hFF, 8'h00, 8'hFF, 1'b1);
        drain();
        write_all(reg_set(1'b0, 8'h00, 8'hFF, 4'hE, 4'h8, 5'd16, 5'd31, 1'b1));
        send_led(8'h01, 8'h80, 8'h7E, 1'b1);
        drain();
        write_all(reg_set(1'b0, 8'hF8, 8'hC0, 4'hE, 4'h8, 5'd31, 5'd16, 1'b0));
        send_led(8'hC0, 8'h03, 8'h99, 1'b1);
        drain();
    endtask

    task automatic test_nibble_packing;
        write_all(reg_set(1'b1, 8'hF8, 8'hC0, 4'hF, 4'h0, 5'd2, 5'd0, 1'b1));
        send_led(8'hA5, 8'h5A, 8'hF0, 1'b0);
        send_led(8'h0F, 8'hFF, 8'h00, 1'b1);
        drain();
        write_all(reg_set(1'b1, 8'hF8, 8'hC0, 4'h0, 4'hF, 5'd0, 5'd3, 1'b0));
        send_led(8'hC6, 8'h39, 8'h81, 1'b1);
        drain();
    endtask

    task automatic test_midframe_config;
        write_all(reg_set(1'b0, 8'hF8, 8'hC0, 4'hE, 4'h8, 5'd1, 5'd1, 1'b1));
        send_led(8'h11, 8'h22, 8'h33, 1'b0);
        drain();
        write_all(reg_set(1'b1, 8'hAA, 8'h55, 4'hC, 4'h3, 5'd5, 5'd2, 1'b0));
        send_led(8'h44, 8'h55, 8'h66, 1'b0);
        send_led(8'h77, 8'h88, 8'h99, 1'b1);
        drain();
    endtask

    task automatic test_backpressure;
        int k;
        hold_until = cycles + 400;
        for (k = 0; k < 8; k++)
            send_led(8'($urandom), 8'($urandom), 8'($urandom), k == 7);
        drain();
    endtask

    function automatic logic [4:0] rand_pad;
        if ($urandom_range(9) == 0)
            return 5'($urandom_range(31, 12));
        return 5'($urandom_range(3));
    endfunction

    task automatic test_random;
        int phase, k;
        for (phase = 0; phase < 5; phase++)
        begin
            write_all(reg_set(1'($urandom), 8'($urandom), 8'($urandom), 4'($urandom),
                              4'($urandom), rand_pad(), rand_pad(), 1'($urandom)));
            gaps_on = (phase != 2);
            for (k = 0; k < 16; k++)
                send_led(8'($urandom), 8'($urandom), 8'($urandom),
                         $urandom_range(3) == 0);
            drain();
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        shadow_regs = reg_set(1'b0, 8'd248, 8'd192, 4'd14, 4'd8, 5'd1, 5'd1, 1'b1);
        in_frame    = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_byte_packing();
        test_nibble_packing();
        test_midframe_config();
        test_backpressure();
        test_random();
        drain();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && spi_bytes_due.size() == 0)
            $display("rgb_led_spi_pulse_encoder_core regression: pass");
        else
            $display("rgb_led_spi_pulse_encoder_core regression: fail");
        $finish;
    end

endmodule

// File: files.f
rtl/core/rlspe_pkg.sv
rtl/core/rlspe_front.sv
rtl/core/rlspe_queue.sv
rtl/core/rlspe_back.sv
rtl/core/rgb_led_spi_pulse_encoder_core.sv
tb/rgb_led_spi_pulse_encoder_core_tb.sv
